FILE: src/aed_pkg.sv
// shared constants for the activity end detector
package aed_pkg;

   // default converter width
   localparam int SAMPLE_BITS_DEF = 10;

   // field widths
   localparam int TICK_BITS  = 16;
   localparam int PHASE_BITS = 3;
   localparam int CSR_ADDR_BITS = 4;
   localparam int CSR_DATA_BITS = 32;

   // register reset values
   localparam int THRESHOLD_RESET = 512;
   localparam logic [TICK_BITS-1:0] TO_ARMED_RESET = 16'd60;
   localparam logic [TICK_BITS-1:0] TO_IDLE_RESET  = 16'd10;
   localparam logic [TICK_BITS-1:0] TO_ALARM_RESET = 16'd120;

   // register indexes (word address)
   localparam logic [1:0] REG_THRESHOLD = 2'd0;
   localparam logic [1:0] REG_TO_ARMED  = 2'd1;
   localparam logic [1:0] REG_TO_IDLE   = 2'd2;
   localparam logic [1:0] REG_TO_ALARM  = 2'd3;

   // item kind
   localparam logic MODE_TICK   = 1'b0;
   localparam logic MODE_SAMPLE = 1'b1;

endpackage

FILE: src/aed_req_if.sv
// input channel: tick or converter sample
interface aed_req_if #(
   parameter int SAMPLE_BITS = aed_pkg::SAMPLE_BITS_DEF
);
   logic                   valid;
   logic                   ready;
   logic                   mode;
   logic [SAMPLE_BITS-1:0] sample;
   logic                   alert_busy;

   modport source (output valid, mode, sample, alert_busy, input ready);
   modport sink   (input valid, mode, sample, alert_busy, output ready);
endinterface

FILE: src/aed_rsp_if.sv
// result channel: phase, elapsed seconds and alarm pulse
interface aed_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [aed_pkg::PHASE_BITS-1:0] phase;
   logic [aed_pkg::TICK_BITS-1:0]  elapsed;
   logic                           alarm_fire;

   modport source (output valid, phase, elapsed, alarm_fire, input ready);
   modport sink   (input valid, phase, elapsed, alarm_fire, output ready);
endinterface

FILE: src/activity_end_detector_fsm_unit.sv
// activity end detector: phase machine with tick counting and apb registers
// an accepted item goes from the input register to the result register, where the result is taken
// throughput: one transaction per cycle while the result register is not held by rsp_ch.ready low
// an input register and a result register part the two channels
// reset (synchronous, active high): phase idle, counters zero, registers at defaults
module activity_end_detector_fsm_unit #(
   parameter int SAMPLE_BITS = aed_pkg::SAMPLE_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   aed_req_if.sink                            req_ch,
   aed_rsp_if.source                          rsp_ch,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [aed_pkg::CSR_ADDR_BITS-1:0]  csr_paddr,
   input  logic [aed_pkg::CSR_DATA_BITS-1:0]  csr_pwdata,
   output logic [aed_pkg::CSR_DATA_BITS-1:0]  csr_prdata,
   output logic                               csr_pready
);
   import aed_pkg::*;

   typedef enum logic [PHASE_BITS-1:0] {
      PH_IDLE   = 3'd0,
      PH_ARM    = 3'd1,
      PH_DISARM = 3'd2,
      PH_ARMED  = 3'd3,
      PH_ALARM  = 3'd4
   } phase_type;

   localparam logic [TICK_BITS-1:0] TICK_MAX = {TICK_BITS{1'b1}};

   // configuration registers
   logic [SAMPLE_BITS-1:0] threshold_ff;
   logic [TICK_BITS-1:0]   to_armed_ff;
   logic [TICK_BITS-1:0]   to_idle_ff;
   logic [TICK_BITS-1:0]   to_alarm_ff;

   // input register
   logic                   in_valid_ff;
   logic                   in_mode_ff;
   logic [SAMPLE_BITS-1:0] in_sample_ff;
   logic                   in_busy_ff;

   // machine state
   phase_type              phase_ff, phase_in;
   logic [TICK_BITS-1:0]   elapsed_ff, elapsed_in;
   logic [TICK_BITS-1:0]   saved_ff, saved_in;
   logic                   fire_in;

   // result register
   logic                   out_valid_ff;
   logic [PHASE_BITS-1:0]  out_phase_ff;
   logic [TICK_BITS-1:0]   out_elapsed_ff;
   logic                   out_fire_ff;

   logic advance;
   logic csr_write;
   logic [1:0] csr_index;
   logic level_high;

   // pipeline flow control
   assign advance      = in_valid_ff && (!out_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !in_valid_ff || advance;

   assign rsp_ch.valid      = out_valid_ff;
   assign rsp_ch.phase      = out_phase_ff;
   assign rsp_ch.elapsed    = out_elapsed_ff;
   assign rsp_ch.alarm_fire = out_fire_ff;

   // apb register access
   assign csr_pready = 1'b1;
   assign csr_index  = csr_paddr[3:2];
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      case (csr_index)
         REG_THRESHOLD: csr_prdata = CSR_DATA_BITS'(threshold_ff);
         REG_TO_ARMED:  csr_prdata = CSR_DATA_BITS'(to_armed_ff);
         REG_TO_IDLE:   csr_prdata = CSR_DATA_BITS'(to_idle_ff);
         REG_TO_ALARM:  csr_prdata = CSR_DATA_BITS'(to_alarm_ff);
         default:       csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= SAMPLE_BITS'(THRESHOLD_RESET);
         to_armed_ff  <= TO_ARMED_RESET;
         to_idle_ff   <= TO_IDLE_RESET;
         to_alarm_ff  <= TO_ALARM_RESET;
      end else if (csr_write) begin
         case (csr_index)
            REG_THRESHOLD: threshold_ff <= csr_pwdata[SAMPLE_BITS-1:0];
            REG_TO_ARMED:  to_armed_ff  <= csr_pwdata[TICK_BITS-1:0];
            REG_TO_IDLE:   to_idle_ff   <= csr_pwdata[TICK_BITS-1:0];
            REG_TO_ALARM:  to_alarm_ff  <= csr_pwdata[TICK_BITS-1:0];
            default: ;
         endcase
      end
   end

   // next phase and elapsed time
   assign level_high = (in_sample_ff >= threshold_ff);

   always_comb begin
      phase_in   = phase_ff;
      elapsed_in = elapsed_ff;
      saved_in   = saved_ff;
      fire_in    = 1'b0;
      if (in_mode_ff == MODE_TICK) begin
         // saturating one-second count
         if (elapsed_ff != TICK_MAX) begin
            elapsed_in = elapsed_ff + 1'b1;
         end
      end else if (!in_busy_ff) begin
         case (phase_ff)
            PH_IDLE: begin
               if (level_high) begin
                  phase_in = PH_ARM;
               end
               elapsed_in = '0;
            end
            PH_ARM: begin
               if (elapsed_ff >= to_armed_ff) begin
                  phase_in   = PH_ARMED;
                  elapsed_in = '0;
               end else if (!level_high) begin
                  saved_in   = elapsed_ff;
                  phase_in   = PH_DISARM;
                  elapsed_in = '0;
               end
            end
            PH_DISARM: begin
               if (elapsed_ff >= to_idle_ff) begin
                  phase_in   = PH_IDLE;
                  elapsed_in = '0;
               end else if (level_high) begin
                  // short dropout resumes with the saved arming time
                  phase_in   = PH_ARM;
                  elapsed_in = saved_ff;
               end
            end
            PH_ARMED: begin
               if (level_high) begin
                  elapsed_in = '0;
               end else if (elapsed_ff >= to_alarm_ff) begin
                  phase_in   = PH_ALARM;
                  elapsed_in = '0;
               end
            end
            PH_ALARM: begin
               fire_in    = 1'b1;
               phase_in   = PH_IDLE;
               elapsed_in = '0;
            end
            default: begin
               phase_in = PH_IDLE;
            end
         endcase
      end
   end

   // state, input register and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         phase_ff     <= PH_IDLE;
         elapsed_ff   <= '0;
         saved_ff     <= '0;
      end else begin
         if (req_ch.ready) begin
            in_valid_ff <= req_ch.valid;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
            phase_ff     <= phase_in;
            elapsed_ff   <= elapsed_in;
            saved_ff     <= saved_in;
         end else if (rsp_ch.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
      if (req_ch.valid && req_ch.ready) begin
         in_mode_ff   <= req_ch.mode;
         in_sample_ff <= req_ch.sample;
         in_busy_ff   <= req_ch.alert_busy;
      end
      if (advance) begin
         out_phase_ff   <= phase_in;
         out_elapsed_ff <= elapsed_in;
         out_fire_ff    <= fire_in;
      end
   end

`ifndef SYNTHESIS
   // an alarm pulse always lands the machine in idle with a cleared count
   a_fire_goes_idle: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_fire_ff) |->
         (out_phase_ff == PH_IDLE && out_elapsed_ff == '0))
      else $error("alarm pulse without return to idle");

   // a tick never changes the phase
   a_tick_keeps_phase: assert property (@(posedge clock) disable iff (reset)
      (advance && in_mode_ff == MODE_TICK) |=> (phase_ff == $past(phase_ff)))
      else $error("tick changed the phase");

   // input stalls only when both registers are full and the result is held
   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      !req_ch.ready |-> (in_valid_ff && out_valid_ff && !rsp_ch.ready))
      else $error("input stalled without backpressure");
`endif

endmodule
